/* rtl/rmir_pkg.sv */
// Package for the running median block: capacity, widths, status codes,
// and the word types of the input and output channels. No dependencies.
`default_nettype none

package rmir_pkg;

    // Number of sorted entries held by the cell chain
    localparam int CAPACITY = 64;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
    localparam int VAL_W    = 32;

    // Operation codes
    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_EMPTY     = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic                    op;
        logic signed [VAL_W-1:0] value;
    } rmir_in_t;

    typedef struct packed {
        logic [1:0]              status;
        logic signed [VAL_W-1:0] median_int;
        logic                    has_half;
        logic                    sum_negative;
    } rmir_out_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic update;
        logic load_out;
    } rmir_cmd_t;

endpackage

`default_nettype wire

/* rtl/rmir_datapath.sv */
// Datapath of the running median block: sorted cell chain, entry count,
// median select and output register. Uses rmir_pkg.
`default_nettype none

module rmir_datapath (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  rmir_pkg::rmir_cmd_t    cmd,
    input  rmir_pkg::rmir_in_t     in_data,
    output rmir_pkg::rmir_out_t    out_data
);

    logic signed [rmir_pkg::VAL_W-1:0] entry_reg  [rmir_pkg::CAPACITY];
    logic signed [rmir_pkg::VAL_W-1:0] entry_next [rmir_pkg::CAPACITY];
    logic [rmir_pkg::CNT_W-1:0]        count_reg;
    logic [rmir_pkg::CNT_W-1:0]        count_next;
    logic [1:0]                        status_reg;
    logic [1:0]                        status_next;
    rmir_pkg::rmir_out_t               out_reg;
    rmir_pkg::rmir_out_t               out_next;

    logic [rmir_pkg::CAPACITY-1:0]     gt_vec;
    logic [rmir_pkg::CAPACITY-1:0]     ge_vec;
    logic [rmir_pkg::CAPACITY-1:0]     eq_vec;
    logic                              found;
    logic                              full;
    logic                              do_insert;
    logic                              do_remove;

    logic [rmir_pkg::IDX_W-1:0]        mid;
    logic [rmir_pkg::IDX_W-1:0]        mid_lo;
    logic signed [rmir_pkg::VAL_W-1:0] hi_val;
    logic signed [rmir_pkg::VAL_W-1:0] lo_val;
    logic signed [rmir_pkg::VAL_W:0]   pair_sum;
    logic signed [rmir_pkg::VAL_W:0]   pair_adj;
    logic signed [rmir_pkg::VAL_W:0]   pair_half;

    // Compare every cell against the incoming word in parallel
    always_comb
    begin
        for (int i = 0; i < rmir_pkg::CAPACITY; i++)
        begin
            if (rmir_pkg::CNT_W'(i) < count_reg)
            begin
                gt_vec[i] = entry_reg[i] > in_data.value;
                ge_vec[i] = entry_reg[i] >= in_data.value;
                eq_vec[i] = entry_reg[i] == in_data.value;
            end
            else
            begin
                // Empty cells sit above every value for an insert
                gt_vec[i] = 1'b1;
                ge_vec[i] = 1'b0;
                eq_vec[i] = 1'b0;
            end
        end
    end

    assign found     = |eq_vec;
    assign full      = count_reg >= rmir_pkg::CNT_W'(rmir_pkg::CAPACITY);
    assign do_insert = cmd.update && (in_data.op == rmir_pkg::OP_ADD) && !full;
    assign do_remove = cmd.update && (in_data.op == rmir_pkg::OP_REMOVE) && found;

    // Shift the chain: right from the insert point, left from the first match
    always_comb
    begin
        for (int i = 0; i < rmir_pkg::CAPACITY; i++)
        begin
            entry_next[i] = entry_reg[i];
        end
        if (do_insert)
        begin
            if (gt_vec[0])
            begin
                entry_next[0] = in_data.value;
            end
            for (int i = 1; i < rmir_pkg::CAPACITY; i++)
            begin
                if (gt_vec[i])
                begin
                    entry_next[i] = gt_vec[i-1] ? entry_reg[i-1] : in_data.value;
                end
            end
        end
        else if (do_remove)
        begin
            for (int i = 0; i < rmir_pkg::CAPACITY - 1; i++)
            begin
                if (ge_vec[i])
                begin
                    entry_next[i] = entry_reg[i+1];
                end
            end
        end
    end

    // Work out the new count and status of the update
    always_comb
    begin
        count_next  = count_reg;
        status_next = status_reg;
        if (cmd.update)
        begin
            status_next = rmir_pkg::ST_OK;
            if (in_data.op == rmir_pkg::OP_ADD)
            begin
                if (full)
                begin
                    status_next = rmir_pkg::ST_FULL;
                end
                else
                begin
                    count_next = count_reg + rmir_pkg::CNT_W'(1);
                end
            end
            else if (count_reg == '0)
            begin
                status_next = rmir_pkg::ST_EMPTY;
            end
            else if (!found)
            begin
                status_next = rmir_pkg::ST_NOT_FOUND;
            end
            else
            begin
                count_next = count_reg - rmir_pkg::CNT_W'(1);
                if (count_reg == rmir_pkg::CNT_W'(1))
                begin
                    status_next = rmir_pkg::ST_EMPTY;
                end
            end
        end
    end

    // Hold the chain; entries need no reset
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < rmir_pkg::CAPACITY; i++)
        begin
            entry_reg[i] <= entry_next[i];
        end
        status_reg <= status_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Select the middle pair from the updated chain
    assign mid    = rmir_pkg::IDX_W'(count_reg >> 1);
    assign mid_lo = mid - rmir_pkg::IDX_W'(1);

    always_comb
    begin
        hi_val = '0;
        lo_val = '0;
        for (int i = 0; i < rmir_pkg::CAPACITY; i++)
        begin
            if (rmir_pkg::IDX_W'(i) == mid)
            begin
                hi_val = entry_reg[i];
            end
            if (rmir_pkg::IDX_W'(i) == mid_lo)
            begin
                lo_val = entry_reg[i];
            end
        end
    end

    // Halve the pair sum, truncating toward zero
    assign pair_sum  = {lo_val[rmir_pkg::VAL_W-1], lo_val}
                     + {hi_val[rmir_pkg::VAL_W-1], hi_val};
    assign pair_adj  = pair_sum + (rmir_pkg::VAL_W+1)'(pair_sum[rmir_pkg::VAL_W] & pair_sum[0]);
    assign pair_half = pair_adj >>> 1;

    always_comb
    begin
        out_next              = '0;
        out_next.status       = status_reg;
        if (status_reg == rmir_pkg::ST_OK)
        begin
            if (count_reg[0])
            begin
                out_next.median_int = hi_val;
            end
            else
            begin
                out_next.median_int   = pair_half[rmir_pkg::VAL_W-1:0];
                out_next.has_half     = pair_sum[0];
                out_next.sum_negative = pair_sum[rmir_pkg::VAL_W];
            end
        end
    end

    // Load the output word
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_reg <= out_next;
        end
    end

    assign out_data = out_reg;

endmodule

`default_nettype wire

/* rtl/rmir_ctrl.sv */
// Controller of the running median block: two-state sequencer and output
// valid flag. Uses rmir_pkg for the command struct.
`default_nettype none

module rmir_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  wire logic           out_ready,
    output rmir_pkg::rmir_cmd_t cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_MED  = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic out_free;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE);

    // Advance: update on accept, then load the result when the output frees up
    always_comb
    begin
        state_next   = state_reg;
        cmd.update   = 1'b0;
        cmd.load_out = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.update = 1'b1;
                    state_next = S_MED;
                end
            end
            S_MED:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold the output word until taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

/* rtl/running_median_insert_remove.sv */
// Top level of the running median block: joins controller and datapath.
// Depends on rmir_pkg, rmir_ctrl and rmir_datapath.
//
//   channel | handshake            | word
//   --------+----------------------+-----------------------------------------
//   in      | in_valid / in_ready  | in_data  (op, value)
//   out     | out_valid / out_ready| out_data (status, median_int, has_half,
//           |                      |           sum_negative)
//
// Per word: the accept in the idle state compares all cells against the value
// and shifts the sorted chain; the median state then picks the middle pair and
// loads the output register. Reset empties the set at once; no clearing pass.
// A stalled output holds the block in its median state; a new word is taken
// while the previous result still waits in the output register.
`default_nettype none

module running_median_insert_remove (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  rmir_pkg::rmir_in_t in_data,
    output logic               out_valid,
    input  wire logic          out_ready,
    output rmir_pkg::rmir_out_t out_data
);

    rmir_pkg::rmir_cmd_t cmd;

    rmir_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    rmir_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_data  (in_data),
        .out_data (out_data)
    );

endmodule

`default_nettype wire
